### sv/glq_pkg.sv
// Shared types, constants and helpers for the glyph quad layout block.
// No dependencies; imported by every module of the block.
package glq_pkg;

    localparam int POS_FRAC_BITS = 4;
    localparam int UV_FRAC_BITS  = 16;

    localparam logic [7:0] CHAR_NEWLINE  = 8'd10;
    localparam logic [7:0] CHAR_FIRST    = 8'd32;
    localparam logic [7:0] CHAR_LAST     = 8'd126;
    localparam logic [7:0] CHAR_FALLBACK = 8'd63;

    localparam int IDX_W = 7;   // printable range 32..126 -> 0..94
    localparam int CFG_W = 17;

    // register indexes of the configuration port
    localparam logic [2:0] CFG_ATLAS_COLUMNS = 3'd0;
    localparam logic [2:0] CFG_DELTA_U       = 3'd1;
    localparam logic [2:0] CFG_DELTA_V       = 3'd2;
    localparam logic [2:0] CFG_HALF_TEXEL_U  = 3'd3;
    localparam logic [2:0] CFG_HALF_TEXEL_V  = 3'd4;
    localparam logic [2:0] CFG_GLYPH_WIDTH   = 3'd5;
    localparam logic [2:0] CFG_GLYPH_HEIGHT  = 3'd6;
    localparam logic [2:0] CFG_ADVANCE_STEP  = 3'd7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_UV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] dividend;
        logic [7:0]       divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] quot;
        logic [7:0]       rem;
    } t_div_rsp;

    typedef struct packed {
        logic [7:0]  factor;
        logic [16:0] delta;
        logic [15:0] offset;
        logic        subtract;
    } t_uv_op;

    // signed 32 bit plus signed 18 bit, saturated to the 32 bit range
    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                    input logic signed [17:0] b);
        logic signed [32:0] sum;
        sum = {a[31], a} + {{15{b[17]}}, b};
        if (sum[32] != sum[31]) begin
            sat_add32 = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sat_add32 = sum[31:0];
        end
    endfunction

endpackage

### sv/glyph_quad_layout_unit.sv
// Glyph quad layout: sequencer, pen state, configuration and output register.
// Depends on glq_pkg, glq_div and glq_uv.
//
//  channel   direction  handshake                    payload
//  input     in         i_in_valid / o_in_stall      i_char_code, i_start_of_text
//  result    out        o_out_valid / i_out_stall    o_x_left .. o_first_vertex
//  config    in         i_cfg_we                     i_cfg_index, i_cfg_data
//
// A newline is handled in the idle state and gives no result. Any other character
// runs through accept, the bit-serial divider, 4 passes through the shared texture
// multiply-add, hand-off and output load; the input stalls until it is done.
// The last step waits while the output register still holds an untaken result.
// Synchronous active-low reset clears pen and vertex count and restores the
// configuration defaults.
module glyph_quad_layout_unit
    import glq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_char_code,
    input  logic               i_start_of_text,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_x_left,
    output logic signed [31:0] o_y_top,
    output logic signed [31:0] o_x_right,
    output logic signed [31:0] o_y_bottom,
    output logic [15:0]        o_u_left,
    output logic [15:0]        o_v_top,
    output logic [15:0]        o_u_right,
    output logic [15:0]        o_v_bottom,
    output logic [31:0]        o_first_vertex,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    // configuration
    logic [7:0]         r_atlas_columns;
    logic [16:0]        r_delta_u;
    logic [16:0]        r_delta_v;
    logic [15:0]        r_half_texel_u;
    logic [15:0]        r_half_texel_v;
    logic [12:0]        r_glyph_width;
    logic [12:0]        r_glyph_height;
    logic signed [16:0] r_advance_step;

    // state
    t_state             r_state;
    t_state             n_state;
    logic signed [31:0] r_pen_x;
    logic signed [31:0] r_pen_y;
    logic [31:0]        r_vcount;
    logic [1:0]         r_uv_sel;
    logic [15:0]        r_uv [4];

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_x_left;
    logic signed [31:0] r_y_top;
    logic signed [31:0] r_x_right;
    logic signed [31:0] r_y_bottom;
    logic [15:0]        r_u_left;
    logic [15:0]        r_v_top;
    logic [15:0]        r_u_right;
    logic [15:0]        r_v_bottom;
    logic [31:0]        r_first_vertex;

    logic               in_accept;
    logic               out_free;
    logic               load_out;
    logic               is_newline;
    logic [7:0]         mapped;
    logic [IDX_W-1:0]   glyph_idx;
    logic signed [17:0] gw;
    logic signed [17:0] gh;
    logic signed [31:0] pen_y_base;
    t_div_req           div_req;
    t_div_rsp           div_rsp;
    t_uv_op             uv_op;
    logic [15:0]        uv_coord;
    logic [7:0]         col;
    logic [7:0]         row;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign is_newline = i_char_code == CHAR_NEWLINE;
    assign mapped     = (i_char_code < CHAR_FIRST || i_char_code > CHAR_LAST) ?
                        CHAR_FALLBACK : i_char_code;
    assign glyph_idx  = IDX_W'(mapped - CHAR_FIRST);
    assign gw         = $signed(18'({5'b0, r_glyph_width} << POS_FRAC_BITS));
    assign gh         = $signed(18'({5'b0, r_glyph_height} << POS_FRAC_BITS));
    assign pen_y_base = i_start_of_text ? 32'sd0 : r_pen_y;
    assign col        = div_rsp.rem;
    assign row        = {1'b0, div_rsp.quot};

    assign div_req.start    = in_accept && !is_newline;
    assign div_req.dividend = glyph_idx;
    assign div_req.divisor  = (r_atlas_columns == 8'd0) ? 8'd1 : r_atlas_columns;

    glq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // pass order: u_left, v_top, u_right, v_bottom
    always_comb begin
        uv_op.subtract = r_uv_sel[1];
        uv_op.factor   = r_uv_sel[0] ? row : col;
        if (r_uv_sel[1]) begin
            uv_op.factor = 8'(uv_op.factor + 8'd1);
        end
        uv_op.delta  = r_uv_sel[0] ? r_delta_v : r_delta_u;
        uv_op.offset = r_uv_sel[0] ? r_half_texel_v : r_half_texel_u;
    end

    glq_uv u_uv (
        .i_op    (uv_op),
        .o_coord (uv_coord)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        load_out   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid && !is_newline) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_UV;
                end
            end
            S_UV: begin
                if (r_uv_sel == 2'd3) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_columns <= 8'd16;
            r_delta_u       <= 17'd4096;
            r_delta_v       <= 17'd4096;
            r_half_texel_u  <= 16'd128;
            r_half_texel_v  <= 16'd128;
            r_glyph_width   <= 13'd16;
            r_glyph_height  <= 13'd16;
            r_advance_step  <= 17'sd272;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ATLAS_COLUMNS: r_atlas_columns <= i_cfg_data[7:0];
                CFG_DELTA_U:       r_delta_u       <= i_cfg_data;
                CFG_DELTA_V:       r_delta_v       <= i_cfg_data;
                CFG_HALF_TEXEL_U:  r_half_texel_u  <= i_cfg_data[15:0];
                CFG_HALF_TEXEL_V:  r_half_texel_v  <= i_cfg_data[15:0];
                CFG_GLYPH_WIDTH:   r_glyph_width   <= i_cfg_data[12:0];
                CFG_GLYPH_HEIGHT:  r_glyph_height  <= i_cfg_data[12:0];
                CFG_ADVANCE_STEP:  r_advance_step  <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x  <= '0;
            r_pen_y  <= '0;
            r_vcount <= '0;
            r_uv_sel <= '0;
        end else begin
            if (in_accept) begin
                if (is_newline) begin
                    r_pen_x <= '0;
                    r_pen_y <= sat_add32(pen_y_base, gh);
                    if (i_start_of_text) begin
                        r_vcount <= '0;
                    end
                end else if (i_start_of_text) begin
                    r_pen_x  <= '0;
                    r_pen_y  <= '0;
                    r_vcount <= '0;
                end
            end
            if (r_state == S_UV) begin
                r_uv_sel <= r_uv_sel + 2'd1;
            end
            if (load_out) begin
                r_vcount <= r_vcount + 32'd4;
                r_pen_x  <= sat_add32(r_pen_x, {r_advance_step[16], r_advance_step});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UV) begin
            r_uv[r_uv_sel] <= uv_coord;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_x_left       <= r_pen_x;
            r_y_top        <= r_pen_y;
            r_x_right      <= sat_add32(r_pen_x, gw);
            r_y_bottom     <= sat_add32(r_pen_y, gh);
            r_u_left       <= r_uv[0];
            r_v_top        <= r_uv[1];
            r_u_right      <= r_uv[2];
            r_v_bottom     <= r_uv[3];
            r_first_vertex <= r_vcount;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_x_left       = r_x_left;
    assign o_y_top        = r_y_top;
    assign o_x_right      = r_x_right;
    assign o_y_bottom     = r_y_bottom;
    assign o_u_left       = r_u_left;
    assign o_v_top        = r_v_top;
    assign o_u_right      = r_u_right;
    assign o_v_bottom     = r_v_bottom;
    assign o_first_vertex = r_first_vertex;

`ifndef ASSERT_OFF
    // a newline never starts the sequencer
    a_newline_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && is_newline |=> r_state == S_IDLE)
        else $error("newline left idle state");

    // each delivered quad steps the vertex number by four
    a_vcount_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> r_vcount == $past(r_vcount) + 32'd4)
        else $error("vertex count did not step by four");

    // divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == S_DIV)
        else $error("divider done outside divide state");

    // each load makes the result valid with the vertex number that it had
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> o_out_valid && o_first_vertex == $past(r_vcount))
        else $error("result register not loaded");
`endif

endmodule

### sv/glq_div.sv
// Bit-serial restoring divider: glyph index by atlas column count.
// Depends on glq_pkg; one quotient bit per cycle.
module glq_div
    import glq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [IDX_W-1:0] r_dvd;
    logic [IDX_W-1:0] r_quot;
    logic [7:0]       r_rem;
    logic [7:0]       r_divisor;
    logic [2:0]       r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [8:0] trial;
    logic       fits;

    assign trial = {r_rem, r_dvd[IDX_W-1]};
    assign fits  = trial >= {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy    <= 1'b1;
                r_cnt     <= 3'(IDX_W);
                r_dvd     <= i_req.dividend;
                r_divisor <= i_req.divisor;
                r_rem     <= '0;
                r_quot    <= '0;
            end else if (r_busy) begin
                r_dvd  <= {r_dvd[IDX_W-2:0], 1'b0};
                r_quot <= {r_quot[IDX_W-2:0], fits};
                r_rem  <= fits ? 8'(trial - {1'b0, r_divisor}) : trial[7:0];
                r_cnt  <= r_cnt - 3'd1;
                if (r_cnt == 3'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

### sv/glq_uv.sv
// Shared texture coordinate unit: factor times delta, plus or minus half texel,
// clamped to Q0.16. Depends on glq_pkg.
module glq_uv
    import glq_pkg::*;
(
    input  t_uv_op      i_op,
    output logic [15:0] o_coord
);

    logic [24:0]        prod;
    logic signed [25:0] sum;

    always_comb begin
        prod = 25'(i_op.factor) * 25'(i_op.delta);
        if (i_op.subtract) begin
            sum = $signed({1'b0, prod}) - $signed({10'b0, i_op.offset});
        end else begin
            sum = $signed({1'b0, prod}) + $signed({10'b0, i_op.offset});
        end
        if (sum[25]) begin
            o_coord = '0;
        end else if (sum[24:UV_FRAC_BITS] != '0) begin
            o_coord = '1;
        end else begin
            o_coord = sum[15:0];
        end
    end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for glyph_quad_layout_unit: directed corner cases, then random text
// with random handshake gaps, checked against an in-bench model of pen, vertex count and atlas
// lookup. Depends on glq_pkg and the glyph_quad_layout_unit RTL.
module tb;
    import glq_pkg::*;

    localparam int    RESET_CYCLES  = 8;
    localparam int    SETTLE_CYCLES = 24;
    localparam int    TAIL_CYCLES   = 40;
    localparam longint LIMIT_CYCLES = 4_000_000;

    typedef struct {
        logic [7:0] code;
        logic       sot;
        logic       hold_for_drain;   // wait until every quad is out before sending
    } t_text_item;

    typedef struct {
        logic signed [31:0] x_left;
        logic signed [31:0] y_top;
        logic signed [31:0] x_right;
        logic signed [31:0] y_bottom;
        logic [15:0]        u_left;
        logic [15:0]        v_top;
        logic [15:0]        u_right;
        logic [15:0]        v_bottom;
        logic [31:0]        first_vertex;
    } t_glyph_quad;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic [7:0]         in_char = '0;
    logic               in_sot = 1'b0;
    logic               out_stall = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [31:0] o_x_left;
    logic signed [31:0] o_y_top;
    logic signed [31:0] o_x_right;
    logic signed [31:0] o_y_bottom;
    logic [15:0]        o_u_left;
    logic [15:0]        o_v_top;
    logic [15:0]        o_u_right;
    logic [15:0]        o_v_bottom;
    logic [31:0]        o_first_vertex;

    // model copy of the block's registers and pen state
    logic [7:0]         atlas_cols;
    logic [16:0]        du;
    logic [16:0]        dv;
    logic [15:0]        half_u;
    logic [15:0]        half_v;
    logic [12:0]        glyph_w;
    logic [12:0]        glyph_h;
    logic signed [16:0] adv_step;
    logic signed [31:0] pen_x;
    logic signed [31:0] pen_y;
    logic [31:0]        vert_num;

    t_text_item  pending[$];
    t_glyph_quad quad_expect[$];

    int unsigned mismatches = 0;
    logic        no_gaps = 1'b0;
    int unsigned tx_gap = 0;
    int unsigned rx_stall_left = 0;
    int unsigned rx_gap;
    logic        tx_valid_next;
    t_text_item  tx_item;
    t_glyph_quad rx_want;
    longint      cycle_count = 0;

    glyph_quad_layout_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_char_code     (in_char),
        .i_start_of_text (in_sot),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_x_left        (o_x_left),
        .o_y_top         (o_y_top),
        .o_x_right       (o_x_right),
        .o_y_bottom      (o_y_bottom),
        .o_u_left        (o_u_left),
        .o_v_top         (o_v_top),
        .o_u_right       (o_u_right),
        .o_v_bottom      (o_v_bottom),
        .o_first_vertex  (o_first_vertex),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [15:0] clamp_uv(input longint v);
        if (v < 0) return 16'h0000;
        if (v > 64'sd65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    // busy_pct: chance in percent of no gap at all; otherwise mostly short, a few long
    function automatic int unsigned pick_gap(input int unsigned busy_pct);
        int unsigned r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < busy_pct) return 0;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic append_quad(input t_glyph_quad q);
        quad_expect.insert(quad_expect.size(), q);
    endtask

    task automatic append_item(input t_text_item it);
        pending.insert(pending.size(), it);
    endtask

    // updates pen and vertex count, queues the expected quad for every character but a newline
    task automatic lay_out_char(input logic [7:0] code, input logic sot);
        t_glyph_quad q;
        logic [7:0]  ch;
        int          idx;
        int          ncols;
        int          col;
        int          row;
        longint      gw;
        longint      gh;
        gw = longint'(glyph_w) * (1 << POS_FRAC_BITS);
        gh = longint'(glyph_h) * (1 << POS_FRAC_BITS);
        if (sot) begin
            pen_x    = '0;
            pen_y    = '0;
            vert_num = '0;
        end
        if (code == CHAR_NEWLINE) begin
            pen_x = '0;
            pen_y = clamp32(longint'(pen_y) + gh);
        end else begin
            ch = (code < CHAR_FIRST || code > CHAR_LAST) ? CHAR_FALLBACK : code;
            idx = int'(ch) - int'(CHAR_FIRST);
            ncols = (atlas_cols == 0) ? 1 : int'(atlas_cols);
            col = idx % ncols;
            row = idx / ncols;
            q.x_left       = pen_x;
            q.y_top        = pen_y;
            q.x_right      = clamp32(longint'(pen_x) + gw);
            q.y_bottom     = clamp32(longint'(pen_y) + gh);
            q.u_left       = clamp_uv(longint'(col) * longint'(du) + longint'(half_u));
            q.v_top        = clamp_uv(longint'(row) * longint'(dv) + longint'(half_v));
            q.u_right      = clamp_uv(longint'(col + 1) * longint'(du) - longint'(half_u));
            q.v_bottom     = clamp_uv(longint'(row + 1) * longint'(dv) - longint'(half_v));
            q.first_vertex = vert_num;
            append_quad(q);
            vert_num = vert_num + 32'd4;
            pen_x = clamp32(longint'(pen_x) + longint'(adv_step));
        end
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s expected %h, got %h", $time, fname, want, got);
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            tx_valid_next = in_valid;
            if (in_valid && !o_in_stall) begin
                lay_out_char(in_char, in_sot);
                tx_valid_next = 1'b0;
            end
            if (!tx_valid_next) begin
                if (tx_gap != 0) begin
                    tx_gap <= tx_gap - 1;
                end else if (pending.size() != 0 &&
                             !(pending[0].hold_for_drain &&
                               (quad_expect.size() != 0 || in_valid))) begin
                    tx_item = pending.pop_front();
                    in_char <= tx_item.code;
                    in_sot  <= tx_item.sot;
                    tx_gap  <= pick_gap(55);
                    tx_valid_next = 1'b1;
                end
            end
            in_valid <= tx_valid_next;
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall     <= 1'b0;
            rx_stall_left <= 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (quad_expect.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: quad expected none, got first_vertex %h",
                             $time, o_first_vertex);
                end else begin
                    rx_want = quad_expect.pop_front();
                    check_field("x_left", rx_want.x_left, o_x_left);
                    check_field("y_top", rx_want.y_top, o_y_top);
                    check_field("x_right", rx_want.x_right, o_x_right);
                    check_field("y_bottom", rx_want.y_bottom, o_y_bottom);
                    check_field("u_left", 32'(rx_want.u_left), 32'(o_u_left));
                    check_field("v_top", 32'(rx_want.v_top), 32'(o_v_top));
                    check_field("u_right", 32'(rx_want.u_right), 32'(o_u_right));
                    check_field("v_bottom", 32'(rx_want.v_bottom), 32'(o_v_bottom));
                    check_field("first_vertex", rx_want.first_vertex, o_first_vertex);
                end
            end
            if (rx_stall_left != 0) begin
                out_stall     <= 1'b1;
                rx_stall_left <= rx_stall_left - 1;
            end else begin
                rx_gap = pick_gap(85);
                out_stall     <= (rx_gap != 0);
                rx_stall_left <= (rx_gap != 0) ? rx_gap - 1 : 0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("glyph_quad_layout_unit: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_ATLAS_COLUMNS: atlas_cols = val[7:0];
            CFG_DELTA_U:       du         = val[16:0];
            CFG_DELTA_V:       dv         = val[16:0];
            CFG_HALF_TEXEL_U:  half_u     = val[15:0];
            CFG_HALF_TEXEL_V:  half_v     = val[15:0];
            CFG_GLYPH_WIDTH:   glyph_w    = val[12:0];
            CFG_GLYPH_HEIGHT:  glyph_h    = val[12:0];
            CFG_ADVANCE_STEP:  adv_step   = val[16:0];
            default: ;
        endcase
    endtask

    task automatic queue_char(input logic [7:0] code, input logic sot);
        t_text_item it;
        it.code           = code;
        it.sot            = sot;
        it.hold_for_drain = 1'b0;
        append_item(it);
    endtask

    // all requests sent, all quads back, then waits the given number of further cycles
    task automatic settle(input int cycles);
        while (pending.size() != 0 || in_valid || quad_expect.size() != 0)
            @(posedge i_clk);
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_reg(input logic [CFG_W-1:0] lo,
                                                   input logic [CFG_W-1:0] hi,
                                                   input logic [CFG_W-1:0] typical);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return typical;
    endfunction

    function automatic t_text_item rand_text_item();
        t_text_item  it;
        int unsigned r;
        r = $urandom_range(0, 99);
        it.hold_for_drain = 1'b0;
        it.sot = ($urandom_range(0, 39) == 0);
        if (r < 8)
            it.code = CHAR_NEWLINE;
        else if (r < 14)
            it.code = 8'($urandom_range(0, 255));
        else
            it.code = 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
        return it;
    endfunction

    task automatic write_random_config();
        int adv;
        adv = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 131071)) - 65536
                                          : int'($urandom_range(0, 1600)) - 200;
        write_reg(CFG_ATLAS_COLUMNS, pick_reg(17'd0, 17'd255, 17'($urandom_range(1, 32))));
        write_reg(CFG_DELTA_U, pick_reg(17'd0, 17'h1FFFF, 17'($urandom_range(0, 16384))));
        write_reg(CFG_DELTA_V, pick_reg(17'd0, 17'h1FFFF, 17'($urandom_range(0, 16384))));
        write_reg(CFG_HALF_TEXEL_U, pick_reg(17'd0, 17'hFFFF, 17'($urandom_range(0, 1024))));
        write_reg(CFG_HALF_TEXEL_V, pick_reg(17'd0, 17'hFFFF, 17'($urandom_range(0, 1024))));
        write_reg(CFG_GLYPH_WIDTH, pick_reg(17'd0, 17'h1FFF, 17'($urandom_range(1, 48))));
        write_reg(CFG_GLYPH_HEIGHT, pick_reg(17'd0, 17'h1FFF, 17'($urandom_range(1, 48))));
        write_reg(CFG_ADVANCE_STEP, pick_reg(17'h10000, 17'h0FFFF, 17'(adv)));
    endtask

    initial begin
        t_text_item it;
        atlas_cols = 8'd16;
        du         = 17'd4096;
        dv         = 17'd4096;
        half_u     = 16'd128;
        half_v     = 16'd128;
        glyph_w    = 13'd16;
        glyph_h    = 13'd16;
        adv_step   = 17'sd272;
        pen_x      = '0;
        pen_y      = '0;
        vert_num   = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: printable bounds, unprintables, newline, restart on newline
        queue_char("H", 1'b1);
        queue_char("i", 1'b0);
        queue_char(CHAR_FIRST, 1'b0);
        queue_char(CHAR_LAST, 1'b0);
        queue_char(8'h00, 1'b0);
        queue_char(8'h1F, 1'b0);
        queue_char(8'h7F, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_char(CHAR_NEWLINE, 1'b0);
        queue_char("!", 1'b0);
        queue_char(CHAR_NEWLINE, 1'b1);
        queue_char("x", 1'b0);
        settle(SETTLE_CYCLES);

        // zero columns, texture overflow high, most negative advance
        write_reg(CFG_ATLAS_COLUMNS, 17'd0);
        write_reg(CFG_DELTA_U, 17'h1FFFF);
        write_reg(CFG_DELTA_V, 17'h1FFFF);
        write_reg(CFG_HALF_TEXEL_U, 17'd0);
        write_reg(CFG_HALF_TEXEL_V, 17'hFFFF);
        write_reg(CFG_GLYPH_WIDTH, 17'h1FFF);
        write_reg(CFG_GLYPH_HEIGHT, 17'd0);
        write_reg(CFG_ADVANCE_STEP, 17'h10000);
        queue_char(CHAR_LAST, 1'b1);
        queue_char(CHAR_FIRST, 1'b0);
        queue_char("5", 1'b0);
        queue_char(8'h9C, 1'b0);
        settle(SETTLE_CYCLES);

        // widest atlas, texture underflow to zero, largest advance
        write_reg(CFG_ATLAS_COLUMNS, 17'd255);
        write_reg(CFG_DELTA_U, 17'd0);
        write_reg(CFG_DELTA_V, 17'd0);
        write_reg(CFG_HALF_TEXEL_U, 17'hFFFF);
        write_reg(CFG_HALF_TEXEL_V, 17'hFFFF);
        write_reg(CFG_GLYPH_WIDTH, 17'd0);
        write_reg(CFG_GLYPH_HEIGHT, 17'h1FFF);
        write_reg(CFG_ADVANCE_STEP, 17'h0FFFF);
        queue_char("a", 1'b1);
        queue_char(CHAR_NEWLINE, 1'b0);
        queue_char("b", 1'b0);
        settle(SETTLE_CYCLES);

        // random text over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            no_gaps = (ph == 1);
            write_random_config();
            for (int n = 0; n < 175; n++) begin
                it = rand_text_item();
                if (n == 0)
                    it.sot = ($urandom_range(0, 4) != 0);
                if ((ph == 2 || ph == 4) && n == 90)
                    it.hold_for_drain = 1'b1;
                append_item(it);
            end
            settle(SETTLE_CYCLES);
        end

        settle(TAIL_CYCLES);
        if (mismatches == 0) begin
            $display("glyph_quad_layout_unit: match");
        end else begin
            $display("glyph_quad_layout_unit: mismatch");
        end
        $finish;
    end

endmodule

### glyph_quad_layout_unit.f
sv/glq_pkg.sv
sv/glq_div.sv
sv/glq_uv.sv
sv/glyph_quad_layout_unit.sv
test/tb.sv
